FILE: hw/rtl/integer_lif_neuron_step_assert.svh
// ---------------------------------------------------------------------------
// integer_lif_neuron_step assertion macros
// Clocked implication checks with active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef INTEGER_LIF_NEURON_STEP_ASSERT_SVH
`define INTEGER_LIF_NEURON_STEP_ASSERT_SVH

// same-cycle implication
`define LIF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lif_pkg.sv
// ---------------------------------------------------------------------------
// lif_pkg
// Shared types and codes for the integer LIF neuron step block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lif_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_RATE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [2:0] REG_LEAK_SHIFT = 3'd0;
    localparam logic [2:0] REG_REST       = 3'd1;
    localparam logic [2:0] REG_THRESH     = 3'd2;
    localparam logic [2:0] REG_RESET_LVL  = 3'd3;
    localparam logic [2:0] REG_SPAN       = 3'd4;
    localparam logic [2:0] REG_REFR       = 3'd5;
    localparam logic [2:0] REG_MIN_POT    = 3'd6;

    localparam int         DIV_W          = 32;
    localparam int         STEP_W         = 6;
    localparam logic [STEP_W-1:0] DIV_STEPS_MOD  = 6'd32;
    localparam logic [STEP_W-1:0] DIV_STEPS_RATE = 6'd16;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] input_current;
        logic [30:0]        random_word;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] potential;
        logic               fired;
        logic [31:0]        count_value;
        logic [16:0]        rate_value;
        logic               rate_undefined;
    } t_out_word;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/lif_div.sv
// ---------------------------------------------------------------------------
// lif_div
// Radix-2 restoring divider, one quotient bit per cycle. The remainder
// register is preloaded from i_num_hi, dividend bits shift in from i_num_lo.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lif_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lif_pkg::t_div_ctl        i_ctl,
    input  wire logic [lif_pkg::DIV_W-1:0] i_num_hi,
    input  wire logic [lif_pkg::DIV_W-1:0] i_num_lo,
    input  wire logic [lif_pkg::DIV_W-1:0] i_den,
    output logic                          o_done,
    output logic [lif_pkg::DIV_W-1:0]     o_quo,
    output logic [lif_pkg::DIV_W-1:0]     o_rem
);
    import lif_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_den;

    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_num_hi;
            r_num <= i_num_lo;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: hw/rtl/integer_lif_neuron_step.sv
// ---------------------------------------------------------------------------
// integer_lif_neuron_step
// Integer leaky integrate-and-fire neuron with tick, count and rate reads.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one word per operation:
//   tick, read-and-clear spike count, read-and-clear spike rate, or no-op.
//   Output channel o_out_valid / i_out_stall returns one word per operation.
//   Configuration registers sit on the APB port at byte address 4*index.
//   Steps from accept to output valid:
//     tick outside refractory: 32-step remainder, leak, sum, fire
//     rate read with ticks above spikes: 16-step serial divide, then rate
//     tick in refractory, count read, no-op, other rate reads: no divide
//   The serial divider is the only long path; one operation is in flight at
//   a time, so a new word waits until the block is idle again.
//   A new word is taken while the previous result still waits in the output
//   register; the block stalls before writing that register until it frees.
//   Synchronous reset loads the register defaults, sets the potential to the
//   rest level, clears all counters and empties the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_lif_neuron_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lif_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lif_pkg::t_out_word o_out_word,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lif_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_LEAK = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_FIRE = 7'b0010000,
        S_RATE = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam logic signed [34:0] SUM_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SUM_MIN = -35'sh0_8000_0000;

    t_state             r_state;

    logic [4:0]         r_leak_shift;
    logic signed [31:0] r_rest;
    logic signed [31:0] r_thresh;
    logic signed [31:0] r_reset_lvl;
    logic [15:0]        r_span;
    logic [15:0]        r_refr_period;
    logic signed [31:0] r_min_pot;

    logic signed [31:0] r_membrane;
    logic [15:0]        r_refr;
    logic [31:0]        r_spikes;
    logic [31:0]        r_ticks;

    logic [1:0]         r_op;
    logic signed [15:0] r_cur;
    logic signed [32:0] r_leak;
    logic signed [34:0] r_part;
    t_out_word          r_res;
    t_out_word          r_out;
    logic               r_out_valid;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [2:0]         w_cfg_idx;
    logic               w_rate_div;
    logic               w_out_free;
    logic               w_fire;
    logic               w_below;
    logic signed [32:0] w_diff;
    logic signed [16:0] w_noise;
    logic signed [34:0] w_sum;
    logic signed [31:0] w_sat;
    t_div_ctl           w_div_ctl;
    logic [DIV_W-1:0]   w_num_hi;
    logic [DIV_W-1:0]   w_num_lo;
    logic [DIV_W-1:0]   w_den;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quo;
    logic [DIV_W-1:0]   w_rem;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_cfg_idx  = paddr[4:2];
    assign pready     = 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_rate_div = (r_ticks != '0) && (r_spikes < r_ticks);

    // divider launch at accept
    always_comb begin
        w_div_ctl.start = w_in_acc &&
            (((i_in_word.opcode == OP_TICK) && (r_refr == '0)) ||
             ((i_in_word.opcode == OP_RATE) && w_rate_div));
        if (i_in_word.opcode == OP_RATE) begin
            w_div_ctl.steps = DIV_STEPS_RATE;
            w_num_hi        = r_spikes;
            w_num_lo        = '0;
            w_den           = r_ticks;
        end else begin
            w_div_ctl.steps = DIV_STEPS_MOD;
            w_num_hi        = '0;
            w_num_lo        = {1'b0, i_in_word.random_word};
            w_den           = {16'b0, r_span};
        end
    end

    lif_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_div_ctl),
        .i_num_hi (w_num_hi),
        .i_num_lo (w_num_lo),
        .i_den    (w_den),
        .o_done   (w_div_done),
        .o_quo    (w_quo),
        .o_rem    (w_rem)
    );

    assign w_diff  = 33'(r_rest) - 33'(r_membrane);
    assign w_noise = $signed({1'b0, w_rem[15:0]}) - $signed({2'b0, r_span[15:1]});
    assign w_sum   = r_part + 35'(r_leak);
    assign w_fire  = (r_membrane > r_thresh);
    assign w_below = (r_membrane < r_min_pot);

    always_comb begin
        if (w_sum > SUM_MAX) begin
            w_sat = SUM_MAX[31:0];
        end else if (w_sum < SUM_MIN) begin
            w_sat = SUM_MIN[31:0];
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_LEAK_SHIFT: prdata = {27'b0, r_leak_shift};
            REG_REST:       prdata = r_rest;
            REG_THRESH:     prdata = r_thresh;
            REG_RESET_LVL:  prdata = r_reset_lvl;
            REG_SPAN:       prdata = {16'b0, r_span};
            REG_REFR:       prdata = {16'b0, r_refr_period};
            REG_MIN_POT:    prdata = r_min_pot;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_leak_shift  <= 5'd4;
            r_rest        <= '0;
            r_thresh      <= 32'sd1000;
            r_reset_lvl   <= '0;
            r_span        <= 16'd1;
            r_refr_period <= '0;
            r_min_pot     <= SUM_MIN[31:0];
            r_membrane    <= '0;
            r_refr        <= '0;
            r_spikes      <= '0;
            r_ticks       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_LEAK_SHIFT: r_leak_shift <= pwdata[4:0];
                    REG_REST: begin
                        r_rest     <= pwdata;
                        r_membrane <= pwdata;
                        r_ticks    <= '0;
                    end
                    REG_THRESH:     r_thresh <= pwdata;
                    REG_RESET_LVL:  r_reset_lvl <= pwdata;
                    REG_SPAN:       r_span <= (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
                    REG_REFR:       r_refr_period <= pwdata[15:0];
                    REG_MIN_POT:    r_min_pot <= pwdata;
                    default: ;
                endcase
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_div_ctl.start) begin
                            r_state <= S_DIV;
                        end else if (i_in_word.opcode == OP_TICK) begin
                            r_refr  <= r_refr - 1'b1;
                            r_state <= S_FIRE;
                        end else begin
                            r_state <= S_RATE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= (r_op == OP_TICK) ? S_LEAK : S_RATE;
                    end
                end
                S_LEAK: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_membrane <= w_sat;
                    r_state    <= S_FIRE;
                end
                S_FIRE: begin
                    if (w_fire) begin
                        r_membrane <= r_reset_lvl;
                        r_refr     <= r_refr_period;
                        if (r_spikes != '1) begin
                            r_spikes <= r_spikes + 1'b1;
                        end
                    end else if (w_below) begin
                        r_membrane <= r_min_pot;
                    end
                    if (r_ticks != '1) begin
                        r_ticks <= r_ticks + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_RATE: begin
                    if (r_op == OP_COUNT) begin
                        r_spikes <= '0;
                    end else if (r_op == OP_RATE) begin
                        r_spikes <= '0;
                        r_ticks  <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_in_word.opcode;
            r_cur <= i_in_word.input_current;
        end
        if (r_state == S_LEAK) begin
            r_leak <= w_diff >>> r_leak_shift;
            r_part <= 35'(r_membrane) + 35'(r_cur) + 35'(w_noise);
        end
        if (r_state == S_FIRE) begin
            r_res.potential      <= w_fire ? r_reset_lvl : (w_below ? r_min_pot : r_membrane);
            r_res.fired          <= w_fire;
            r_res.count_value    <= '0;
            r_res.rate_value     <= '0;
            r_res.rate_undefined <= 1'b0;
        end
        if (r_state == S_RATE) begin
            r_res.potential      <= r_membrane;
            r_res.fired          <= 1'b0;
            r_res.count_value    <= ((r_op == OP_COUNT) || (r_op == OP_RATE)) ? r_spikes : '0;
            r_res.rate_undefined <= (r_op == OP_RATE) && (r_ticks == '0);
            if ((r_op != OP_RATE) || (r_ticks == '0)) begin
                r_res.rate_value <= '0;
            end else if (r_spikes >= r_ticks) begin
                r_res.rate_value <= 17'h10000;
            end else begin
                r_res.rate_value <= {1'b0, w_quo[15:0]};
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`include "integer_lif_neuron_step_assert.svh"

    `LIF_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "divider done outside divide state")
    `LIF_ASSERT_NEXT(a_tick_starts_div, i_clk, i_rst_n, w_in_acc && (i_in_word.opcode == OP_TICK) && (r_refr == '0), r_state == S_DIV, "live tick did not start divider")
    `LIF_ASSERT_NEXT(a_spike_loads_refr, i_clk, i_rst_n, (r_state == S_FIRE) && w_fire, r_refr == $past(r_refr_period), "spike did not reload refractory")
    `LIF_ASSERT_NOW(a_rate_bound, i_clk, i_rst_n, o_out_valid, o_out_word.rate_value <= 17'h10000, "rate above one")

endmodule

`default_nettype wire
